[src/pts_pkg.sv]
package pts_pkg;

   localparam int NOTE_AW     = 8;
   localparam int NOTE_DEPTH  = 1 << NOTE_AW;
   localparam int SOUND_AW    = 4;
   localparam int SOUND_SLOTS = 1 << SOUND_AW;

   localparam logic [7:0] IDLE_PRIORITY = 8'hFF;

   typedef enum logic [2:0] {
      OP_TICK     = 3'd0,
      OP_PLAY     = 3'd1,
      OP_STOP     = 3'd2,
      OP_NOTE_WR  = 3'd3,
      OP_SOUND_WR = 3'd4
   } opcode_type;

   typedef struct packed {
      logic [15:0] freq;
      logic [15:0] dur;
   } note_type;

   typedef struct packed {
      logic [NOTE_AW-1:0] start;
      logic [7:0]         prio;
      logic               loops;
      logic               present;
   } sound_type;

   typedef struct packed {
      opcode_type          op;
      logic [SOUND_AW-1:0] id;
      sound_type           snd;
   } item_type;

   typedef struct packed {
      logic [SOUND_AW-1:0] playing_id;
      logic [NOTE_AW-1:0]  base;
      logic [NOTE_AW-1:0]  pos;
   } seq_pos_type;

   typedef struct packed {
      logic                valid;
      logic [SOUND_AW-1:0] id;
      logic [7:0]          prio;
   } prio_wr_type;

   typedef struct packed {
      logic [15:0]         tone_freq;
      logic                tone_changed;
      logic [SOUND_AW-1:0] current_sound;
   } result_type;

endpackage

[src/pts_note_mem.sv]
module pts_note_mem (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [pts_pkg::NOTE_AW-1:0] wr_addr,
   input  pts_pkg::note_type          wr_data,
   input  logic                       rd_en,
   input  logic [pts_pkg::NOTE_AW-1:0] rd_addr_a,
   input  logic [pts_pkg::NOTE_AW-1:0] rd_addr_b,
   output pts_pkg::note_type          rd_data_a,
   output pts_pkg::note_type          rd_data_b
);
   import pts_pkg::*;

   note_type mem_ff [NOTE_DEPTH];
   note_type rd_a_ff;
   note_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

[src/pts_sound_table.sv]
module pts_sound_table (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  logic [pts_pkg::SOUND_AW-1:0] wr_id,
   input  pts_pkg::sound_type          wr_data,
   input  logic [pts_pkg::SOUND_AW-1:0] rd_id,
   output pts_pkg::sound_type          rd_data
);
   import pts_pkg::*;

   sound_type tbl_ff [SOUND_SLOTS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SOUND_SLOTS; i++) begin
            tbl_ff[i] <= '{start: '0, prio: IDLE_PRIORITY, loops: 1'b0, present: 1'b0};
         end
      end else if (wr_en) begin
         tbl_ff[wr_id] <= wr_data;
      end
   end

   assign rd_data = tbl_ff[rd_id];

endmodule

[src/pts_player.sv]
module pts_player (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 go,
   input  pts_pkg::item_type    item,
   input  pts_pkg::note_type    note_a,
   input  pts_pkg::note_type    note_b,
   input  pts_pkg::prio_wr_type prio_wr,
   output pts_pkg::seq_pos_type seq_next,
   output pts_pkg::result_type  result
);
   import pts_pkg::*;

   logic [SOUND_AW-1:0] playing_id_ff, playing_id_in;
   logic [NOTE_AW-1:0]  base_ff, base_in;
   logic [NOTE_AW-1:0]  pos_ff, pos_in;
   logic [15:0]         elapsed_ff, elapsed_in;
   logic                loop_ff, loop_in;
   logic [15:0]         cur_dur_ff, cur_dur_in;
   logic [15:0]         cur_freq_ff, cur_freq_in;
   logic [7:0]          cur_prio_ff, cur_prio_in;

   logic [15:0] elapsed_inc;
   logic [7:0]  active_prio;
   logic        changed;
   logic        latch_a;
   logic        latch_b;
   logic        halt;

   always_ff @(posedge clock) begin
      if (reset) begin
         playing_id_ff <= '0;
         base_ff       <= '0;
         pos_ff        <= '0;
         elapsed_ff    <= '0;
         loop_ff       <= 1'b0;
         cur_dur_ff    <= '0;
         cur_freq_ff   <= '0;
         cur_prio_ff   <= IDLE_PRIORITY;
      end else begin
         playing_id_ff <= playing_id_in;
         base_ff       <= base_in;
         pos_ff        <= pos_in;
         elapsed_ff    <= elapsed_in;
         loop_ff       <= loop_in;
         cur_dur_ff    <= cur_dur_in;
         cur_freq_ff   <= cur_freq_in;
         cur_prio_ff   <= cur_prio_in;
      end
   end

   always_comb begin
      playing_id_in = playing_id_ff;
      base_in       = base_ff;
      pos_in        = pos_ff;
      elapsed_in    = elapsed_ff;
      loop_in       = loop_ff;
      cur_dur_in    = cur_dur_ff;
      cur_freq_in   = cur_freq_ff;
      cur_prio_in   = cur_prio_ff;
      changed       = 1'b0;
      latch_a       = 1'b0;
      latch_b       = 1'b0;
      halt          = 1'b0;

      elapsed_inc = (elapsed_ff == 16'hFFFF) ? elapsed_ff : elapsed_ff + 16'd1;
      active_prio = (playing_id_ff == '0) ? IDLE_PRIORITY : cur_prio_ff;

      if (go) begin
         case (item.op)
            OP_TICK: begin
               if (playing_id_ff != '0) begin
                  elapsed_in = elapsed_inc;
                  if (elapsed_inc >= cur_dur_ff) begin
                     changed = 1'b1;
                     pos_in  = pos_ff + NOTE_AW'(1);
                     if (note_a.dur != '0) begin
                        latch_a = 1'b1;
                     end else if (loop_ff && note_b.dur != '0) begin
                        pos_in  = '0;
                        latch_b = 1'b1;
                     end else begin
                        halt = 1'b1;
                     end
                  end
               end
            end
            OP_PLAY: begin
               if (item.id != '0 && item.snd.prio <= active_prio) begin
                  changed       = 1'b1;
                  playing_id_in = item.id;
                  loop_in       = item.snd.loops;
                  base_in       = item.snd.start;
                  pos_in        = '0;
                  elapsed_in    = '0;
                  cur_prio_in   = item.snd.prio;
                  if (item.snd.present && note_a.dur != '0) begin
                     latch_a = 1'b1;
                  end else begin
                     halt = 1'b1;
                  end
               end
            end
            OP_STOP: begin
               changed = 1'b1;
               halt    = 1'b1;
            end
            default: begin
            end
         endcase
      end

      if (latch_a) begin
         cur_freq_in = note_a.freq;
         cur_dur_in  = note_a.dur;
         elapsed_in  = '0;
      end
      if (latch_b) begin
         cur_freq_in = note_b.freq;
         cur_dur_in  = note_b.dur;
         elapsed_in  = '0;
      end
      if (halt) begin
         playing_id_in = '0;
         pos_in        = '0;
         loop_in       = 1'b0;
         cur_freq_in   = '0;
         cur_dur_in    = '0;
         elapsed_in    = '0;
      end

      // A table write that lands with this word follows it in program order.
      if (prio_wr.valid && prio_wr.id == playing_id_in) begin
         cur_prio_in = prio_wr.prio;
      end
   end

   assign seq_next = '{playing_id: playing_id_in, base: base_in, pos: pos_in};
   assign result   = '{tone_freq: cur_freq_in, tone_changed: changed,
                       current_sound: playing_id_in};

   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      playing_id_ff == '0 |-> cur_freq_ff == '0 && cur_dur_ff == '0)
      else $error("idle player holds a tone");

   a_idle_cleared: assert property (@(posedge clock) disable iff (reset)
      playing_id_ff == '0 |-> pos_ff == '0 && !loop_ff && elapsed_ff == '0)
      else $error("idle player holds sequence position");

   a_playing_dur: assert property (@(posedge clock) disable iff (reset)
      playing_id_ff != '0 |-> cur_dur_ff != '0)
      else $error("playing note latched with zero duration");

endmodule

[src/priority_tone_sequencer_top.sv]
// Sound-effect tone sequencer.
// The req channel carries one command word per handshake: a one-millisecond
// tick, a play or stop request, a note memory write or a sound table write.
// The rsp channel returns exactly one word per accepted command, in order,
// with the tone frequency now driven, a flag for a note change or stop, and
// the id of the playing sound.
// An accepted word reads the sound table and the dual-read note memory at
// once; when the output register is free or being read, the player stage
// updates its state from the registered read data and loads the output
// register. The note memory addresses come from the player's next state, so
// one word is accepted every cycle while rsp_ready is high. When the receiver
// stalls, the response is held in the output register, one more word waits
// in the player stage, and req_ready then drops.
// Reset clears the sound table to absent entries of priority 255 and makes
// the player idle and silent. The note memory is not cleared, so every note
// that a sound can reach must be written before it plays.
module priority_tone_sequencer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_opcode,
   input  logic [3:0]  req_sound_id,
   input  logic [7:0]  req_note_addr,
   input  logic [15:0] req_note_freq,
   input  logic [15:0] req_note_dur,
   input  logic [7:0]  req_seq_start,
   input  logic [7:0]  req_prio_value,
   input  logic        req_loops,
   input  logic        req_present,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_tone_freq,
   output logic        rsp_tone_changed,
   output logic [3:0]  rsp_current_sound
);
   import pts_pkg::*;

   logic        s2_valid_ff, s2_valid_in;
   item_type    s2_item_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_data_ff;

   logic        s2_go;
   logic        req_accept;
   opcode_type  req_op;
   sound_type   tbl_rd;
   sound_type   tbl_wr;
   note_type    note_wr;
   note_type    note_a;
   note_type    note_b;
   seq_pos_type seq_next;
   result_type  result;
   prio_wr_type prio_wr;
   logic [NOTE_AW-1:0] rd_addr_a;

   assign req_op     = opcode_type'(req_opcode);
   assign s2_go      = s2_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s2_valid_ff || s2_go;
   assign req_accept = req_valid && req_ready;

   assign tbl_wr  = '{start: req_seq_start, prio: req_prio_value, loops: req_loops,
                      present: req_present};
   assign note_wr = '{freq: req_note_freq, dur: req_note_dur};
   assign prio_wr = '{valid: req_accept && req_op == OP_SOUND_WR, id: req_sound_id,
                      prio: req_prio_value};

   assign rd_addr_a = (req_op == OP_PLAY) ? tbl_rd.start
                                          : seq_next.base + seq_next.pos + NOTE_AW'(1);

   pts_sound_table u_sound_table (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (req_accept && req_op == OP_SOUND_WR),
      .wr_id   (req_sound_id),
      .wr_data (tbl_wr),
      .rd_id   (req_sound_id),
      .rd_data (tbl_rd)
   );

   pts_note_mem u_note_mem (
      .clock     (clock),
      .wr_en     (req_accept && req_op == OP_NOTE_WR),
      .wr_addr   (req_note_addr),
      .wr_data   (note_wr),
      .rd_en     (req_accept),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (seq_next.base),
      .rd_data_a (note_a),
      .rd_data_b (note_b)
   );

   pts_player u_player (
      .clock    (clock),
      .reset    (reset),
      .go       (s2_go),
      .item     (s2_item_ff),
      .note_a   (note_a),
      .note_b   (note_b),
      .prio_wr  (prio_wr),
      .seq_next (seq_next),
      .result   (result)
   );

   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (req_accept) begin
         s2_valid_in = 1'b1;
      end else if (s2_go) begin
         s2_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s2_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s2_item_ff <= '{op: req_op, id: req_sound_id, snd: tbl_rd};
      end
      if (s2_go) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_tone_freq     = rsp_data_ff.tone_freq;
   assign rsp_tone_changed  = rsp_data_ff.tone_changed;
   assign rsp_current_sound = rsp_data_ff.current_sound;

   a_rsp_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff)
      else $error("stalled response word dropped");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && rsp_valid_ff && !rsp_ready |=> s2_valid_ff && $stable(s2_item_ff))
      else $error("waiting word in player stage overwritten");

   a_one_per_word: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s2_valid_ff)
      else $error("accepted word lost before the player stage");

endmodule

[test/tb_priority_tone_sequencer_top.sv]
module tb_priority_tone_sequencer_top;
   import pts_pkg::*;

   localparam int CLOCK_HALF      = 4;
   localparam int RESET_CYCLES    = 10;
   localparam int RSP_HOLD_CYCLES = 100;
   localparam int TAIL_CYCLES     = 20;
   localparam int CYCLE_LIMIT     = 400000;

   localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

   typedef struct {
      logic [2:0]  op;
      logic [3:0]  id;
      logic [7:0]  note_addr;
      logic [15:0] note_freq;
      logic [15:0] note_dur;
      logic [7:0]  seq_start;
      logic [7:0]  prio_value;
      logic        loops;
      logic        present;
   } req_word_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_opcode;
   logic [3:0]  req_sound_id;
   logic [7:0]  req_note_addr;
   logic [15:0] req_note_freq;
   logic [15:0] req_note_dur;
   logic [7:0]  req_seq_start;
   logic [7:0]  req_prio_value;
   logic        req_loops;
   logic        req_present;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [15:0] rsp_tone_freq;
   logic        rsp_tone_changed;
   logic [3:0]  rsp_current_sound;

   note_type    note_tab [NOTE_DEPTH];
   sound_type   sound_tab [SOUND_SLOTS];
   logic [3:0]  cur_id;
   logic [7:0]  cur_base;
   logic [7:0]  cur_pos;
   logic [15:0] cur_elapsed;
   logic        cur_loop;
   logic [15:0] cur_len;
   logic [15:0] cur_hz;

   result_type  expected_tones [$];
   int unsigned words_sent;
   int unsigned fault_count;
   int unsigned cycle_count;
   bit          sender_gaps_on;
   bit          rsp_stalls_on;
   bit          rsp_hold_request;

   priority_tone_sequencer_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_sound_id      (req_sound_id),
      .req_note_addr     (req_note_addr),
      .req_note_freq     (req_note_freq),
      .req_note_dur      (req_note_dur),
      .req_seq_start     (req_seq_start),
      .req_prio_value    (req_prio_value),
      .req_loops         (req_loops),
      .req_present       (req_present),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_tone_freq     (rsp_tone_freq),
      .rsp_tone_changed  (rsp_tone_changed),
      .rsp_current_sound (rsp_current_sound)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   function automatic void halt_tone();
      cur_id      = '0;
      cur_pos     = '0;
      cur_loop    = 1'b0;
      cur_hz      = '0;
      cur_len     = '0;
      cur_elapsed = '0;
   endfunction

   function automatic logic latch_note();
      logic [NOTE_AW-1:0] addr;
      note_type           n;
      addr = cur_base + cur_pos;
      n    = note_tab[addr];
      if (n.dur == '0) begin
         return 1'b0;
      end
      cur_hz      = n.freq;
      cur_len     = n.dur;
      cur_elapsed = '0;
      return 1'b1;
   endfunction

   function automatic result_type predict_tone(input req_word_type w);
      result_type r;
      logic [7:0] playing_prio;
      logic       changed;
      changed = 1'b0;
      case (w.op)
         OP_TICK: begin
            if (cur_id != '0) begin
               if (cur_elapsed != 16'hFFFF) begin
                  cur_elapsed++;
               end
               if (cur_elapsed >= cur_len) begin
                  changed = 1'b1;
                  cur_pos++;
                  if (!latch_note()) begin
                     cur_pos = '0;
                     if (!cur_loop || !latch_note()) begin
                        halt_tone();
                     end
                  end
               end
            end
         end
         OP_PLAY: begin
            if (w.id != '0) begin
               playing_prio = (cur_id == '0) ? IDLE_PRIORITY : sound_tab[cur_id].prio;
               if (sound_tab[w.id].prio <= playing_prio) begin
                  changed     = 1'b1;
                  cur_id      = w.id;
                  cur_loop    = sound_tab[w.id].loops;
                  cur_base    = sound_tab[w.id].start;
                  cur_pos     = '0;
                  cur_elapsed = '0;
                  if (!sound_tab[w.id].present || !latch_note()) begin
                     halt_tone();
                  end
               end
            end
         end
         OP_STOP: begin
            halt_tone();
            changed = 1'b1;
         end
         OP_NOTE_WR: begin
            note_tab[w.note_addr] = '{freq: w.note_freq, dur: w.note_dur};
         end
         OP_SOUND_WR: begin
            sound_tab[w.id] = '{start: w.seq_start, prio: w.prio_value,
                                loops: w.loops, present: w.present};
         end
         default: begin
         end
      endcase
      r.tone_freq     = cur_hz;
      r.tone_changed  = changed;
      r.current_sound = cur_id;
      return r;
   endfunction

   function automatic req_word_type random_payload();
      req_word_type w;
      w.op         = 3'($urandom_range(0, 7));
      w.id         = 4'($urandom);
      w.note_addr  = 8'($urandom);
      w.note_freq  = 16'($urandom);
      w.note_dur   = 16'($urandom);
      w.seq_start  = 8'($urandom);
      w.prio_value = 8'($urandom);
      w.loops      = 1'($urandom);
      w.present    = 1'($urandom);
      return w;
   endfunction

   function automatic logic [15:0] random_duration();
      int unsigned pick;
      pick = $urandom_range(0, 31);
      if (pick < 4) begin
         return '0;
      end else if (pick == 4) begin
         return 16'($urandom_range(0, 65535));
      end
      return 16'($urandom_range(1, 4));
   endfunction

   function automatic logic [15:0] random_frequency();
      if ($urandom_range(0, 7) == 0) begin
         return '0;
      end
      return 16'($urandom);
   endfunction

   function automatic req_word_type random_word();
      req_word_type w;
      int unsigned  pick;
      int unsigned  prio_pick;
      w    = random_payload();
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         w.op = OP_TICK;
      end else if (pick < 60) begin
         w.op = OP_PLAY;
         w.id = ($urandom_range(0, 19) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
      end else if (pick < 65) begin
         w.op = OP_STOP;
      end else if (pick < 80) begin
         w.op        = OP_NOTE_WR;
         w.note_freq = random_frequency();
         w.note_dur  = random_duration();
      end else if (pick < 97) begin
         w.op      = OP_SOUND_WR;
         prio_pick = $urandom_range(0, 15);
         if (prio_pick == 0) begin
            w.prio_value = '0;
         end else if (prio_pick == 1) begin
            w.prio_value = IDLE_PRIORITY;
         end else if (prio_pick > 2) begin
            w.prio_value = 8'($urandom_range(1, 6));
         end
         w.present = ($urandom_range(0, 7) != 0);
      end else begin
         w.op = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
      end
      return w;
   endfunction

   task automatic send_word(input req_word_type w);
      int unsigned gap;
      if (sender_gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 12);
         repeat (gap) begin
            @(negedge clock);
            req_valid = 1'b0;
         end
      end
      @(negedge clock);
      req_opcode     = w.op;
      req_sound_id   = w.id;
      req_note_addr  = w.note_addr;
      req_note_freq  = w.note_freq;
      req_note_dur   = w.note_dur;
      req_seq_start  = w.seq_start;
      req_prio_value = w.prio_value;
      req_loops      = w.loops;
      req_present    = w.present;
      req_valid      = 1'b1;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      expected_tones.push_back(predict_tone(w));
      words_sent++;
   endtask

   task automatic send_cmd(input logic [2:0] op, input logic [3:0] id);
      req_word_type w;
      w    = random_payload();
      w.op = op;
      w.id = id;
      send_word(w);
   endtask

   task automatic write_note(input logic [7:0] addr, input logic [15:0] freq,
                             input logic [15:0] dur);
      req_word_type w;
      w           = random_payload();
      w.op        = OP_NOTE_WR;
      w.note_addr = addr;
      w.note_freq = freq;
      w.note_dur  = dur;
      send_word(w);
   endtask

   task automatic write_sound(input logic [3:0] id, input logic [7:0] start,
                              input logic [7:0] prio, input logic loops,
                              input logic present);
      req_word_type w;
      w            = random_payload();
      w.op         = OP_SOUND_WR;
      w.id         = id;
      w.seq_start  = start;
      w.prio_value = prio;
      w.loops      = loops;
      w.present    = present;
      send_word(w);
   endtask

   task automatic drain_tones();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_tones.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // The note memory comes out of reset undefined, so every entry is
   // written before any sound can reach it.
   task automatic test_note_fill();
      for (int a = 0; a < NOTE_DEPTH; a++) begin
         write_note(8'(a), random_frequency(), random_duration());
      end
   endtask

   task automatic test_idle_commands();
      send_cmd(OP_TICK, 4'd0);
      send_cmd(OP_STOP, 4'd0);
      send_cmd(OP_PLAY, 4'd0);
      send_cmd(OP_PLAY, 4'd5);
      for (int op = OP_UNUSED_FIRST; op <= OP_UNUSED_LAST; op++) begin
         send_cmd(3'(op), 4'($urandom));
      end
   endtask

   // A looping sound wraps once, then its first note is rewritten to end
   // the sequence while it is still latched, so the next wrap stops it.
   task automatic test_loop_and_empty_loop();
      write_note(8'd250, 16'd440, 16'd1);
      write_note(8'd251, 16'd0, 16'd2);
      write_note(8'd252, 16'd1234, 16'd0);
      write_sound(4'd1, 8'd250, 8'd10, 1'b1, 1'b1);
      send_cmd(OP_PLAY, 4'd1);
      repeat (3) send_cmd(OP_TICK, 4'd0);
      write_note(8'd250, 16'd880, 16'd0);
      repeat (3) send_cmd(OP_TICK, 4'd0);
   endtask

   task automatic test_priority_rules();
      write_note(8'd253, 16'hFFFF, 16'hFFFF);
      write_note(8'd254, 16'd7, 16'd0);
      write_note(8'd255, 16'd1000, 16'd1);
      write_sound(4'd2, 8'd253, 8'd255, 1'b0, 1'b1);
      write_sound(4'd3, 8'd255, 8'd0, 1'b0, 1'b1);
      write_sound(4'd15, 8'd252, 8'd100, 1'b1, 1'b1);
      write_sound(4'd0, 8'd255, 8'd0, 1'b1, 1'b1);
      send_cmd(OP_PLAY, 4'd2);
      send_cmd(OP_TICK, 4'd0);
      send_cmd(OP_PLAY, 4'd15);
      send_cmd(OP_PLAY, 4'd2);
      send_cmd(OP_PLAY, 4'd3);
      send_cmd(OP_PLAY, 4'd2);
      send_cmd(OP_PLAY, 4'd3);
      send_cmd(OP_TICK, 4'd0);
      send_cmd(OP_PLAY, 4'd0);
      send_cmd(OP_STOP, 4'd0);
   endtask

   task automatic test_random_traffic(input int unsigned count);
      for (int s = 0; s < SOUND_SLOTS; s++) begin
         write_sound(4'(s), 8'($urandom), 8'($urandom_range(0, 6)), 1'($urandom),
                     ($urandom_range(0, 5) != 0));
      end
      repeat (count) send_word(random_word());
   endtask

   task automatic test_rsp_backpressure();
      bit gaps_saved;
      gaps_saved       = sender_gaps_on;
      sender_gaps_on   = 1'b0;
      rsp_hold_request = 1'b1;
      repeat (24) send_word(random_word());
      sender_gaps_on = gaps_saved;
   endtask

   initial begin
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if (rsp_hold_request) begin
            rsp_ready = 1'b0;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
            rsp_hold_request = 1'b0;
         end else if (rsp_stalls_on && $urandom_range(0, 3) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end else begin
            rsp_ready = 1'b1;
            @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_tones.size() == 0) begin
            $error("unexpected response word: tone_freq %0d tone_changed %0d current_sound %0d",
                   rsp_tone_freq, rsp_tone_changed, rsp_current_sound);
            fault_count++;
         end else begin
            want = expected_tones.pop_front();
            if (rsp_tone_freq !== want.tone_freq) begin
               $error("tone_freq: expected %0d, got %0d", want.tone_freq, rsp_tone_freq);
               fault_count++;
            end
            if (rsp_tone_changed !== want.tone_changed) begin
               $error("tone_changed: expected %0d, got %0d", want.tone_changed,
                      rsp_tone_changed);
               fault_count++;
            end
            if (rsp_current_sound !== want.current_sound) begin
               $error("current_sound: expected %0d, got %0d", want.current_sound,
                      rsp_current_sound);
               fault_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d responses outstanding",
                  cycle_count, expected_tones.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_opcode       = '0;
      req_sound_id     = '0;
      req_note_addr    = '0;
      req_note_freq    = '0;
      req_note_dur     = '0;
      req_seq_start    = '0;
      req_prio_value   = '0;
      req_loops        = 1'b0;
      req_present      = 1'b0;
      words_sent       = 0;
      fault_count      = 0;
      cycle_count      = 0;
      sender_gaps_on   = 1'b1;
      rsp_stalls_on    = 1'b1;
      rsp_hold_request = 1'b0;
      for (int a = 0; a < NOTE_DEPTH; a++) begin
         note_tab[a] = '0;
      end
      for (int s = 0; s < SOUND_SLOTS; s++) begin
         sound_tab[s] = '{start: '0, prio: IDLE_PRIORITY, loops: 1'b0, present: 1'b0};
      end
      cur_base = '0;
      halt_tone();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_note_fill();
      test_idle_commands();
      test_loop_and_empty_loop();
      test_priority_rules();
      test_random_traffic(1000);
      test_rsp_backpressure();
      sender_gaps_on = 1'b0;
      rsp_stalls_on  = 1'b0;
      test_random_traffic(400);

      drain_tones();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Sent %0d command words: note fill, idle commands, looping and empty loops,",
               words_sent);
      $display("priority takeover and refusal, random traffic and a long response hold-off.");
      if (fault_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches", fault_count);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
